[hdl/pftp_pkg.sv]
package pftp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 48;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEGEN = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

endpackage

[hdl/pftp_pts_if.sv]
interface pftp_pts_if #(
  parameter int COORD_WIDTH = pftp_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x0;
  logic signed [COORD_WIDTH-1:0] y0;
  logic signed [COORD_WIDTH-1:0] z0;
  logic signed [COORD_WIDTH-1:0] x1;
  logic signed [COORD_WIDTH-1:0] y1;
  logic signed [COORD_WIDTH-1:0] z1;
  logic signed [COORD_WIDTH-1:0] x2;
  logic signed [COORD_WIDTH-1:0] y2;
  logic signed [COORD_WIDTH-1:0] z2;

  modport source (output valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, input ready);
  modport sink   (input valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, output ready);
endinterface

[hdl/pftp_coef_if.sv]
interface pftp_coef_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pftp_pkg::OUT_WIDTH-1:0] coef_a;
  logic signed [pftp_pkg::OUT_WIDTH-1:0] coef_b;
  logic signed [pftp_pkg::OUT_WIDTH-1:0] coef_c;
  logic        [1:0]                     status;

  modport source (output valid, coef_a, coef_b, coef_c, status, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, status, output ready);
endinterface

[hdl/pftp_mul.sv]
// Signed multiplier in two register stages: the a operand is split in halves,
// both partial products are registered, then recombined.
module pftp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);
  localparam int LW = AW / 2;
  localparam int HW = AW - LW;
  localparam int PW = AW + BW;

  logic signed [LW+BW:0]   pl_d, pl_q;
  logic signed [HW+BW-1:0] ph_d, ph_q;
  logic signed [PW-1:0]    p_q;

  assign pl_d = $signed({1'b0, a_i[LW-1:0]}) * b_i;
  assign ph_d = $signed(a_i[AW-1:LW]) * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
      p_q  <= (PW'(ph_q) <<< LW) + PW'(pl_q);
    end
  end

  assign p_o = p_q;
endmodule

[hdl/pftp_div.sv]
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// Quotient of (num << SH) / den, OW bits; ovf_o flags a quotient of 2^OW or more.
module pftp_div #(
  parameter int NW = 67,
  parameter int DW = 99,
  parameter int SH = 32,
  parameter int OW = 48
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [OW-1:0] quo_o,
  output logic          ovf_o
);
  localparam int XW = NW + SH;
  localparam int CW = ((XW > DW) ? XW : DW) + 1;

  logic [XW+OW-1:0] ext;
  logic [CW-1:0]    rem_q [OW+1];
  logic [OW-1:0]    low_q [OW+1];
  logic [OW-1:0]    quo_q [OW+1];
  logic [DW-1:0]    den_q [OW+1];
  logic             ovf_q [OW+1];

  assign ext = (XW + OW)'(num_i) << SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(ext[XW+OW-1:OW]);
      low_q[0] <= ext[OW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= CW'(ext[XW+OW-1:OW]) >= CW'(den_i);
    end
  end

  for (genvar k = 1; k <= OW; k++) begin : g_step
    logic [CW-1:0] r2;
    logic          ge;

    assign r2 = {rem_q[k-1][CW-2:0], low_q[k-1][OW-1]};
    assign ge = r2 >= CW'(den_q[k-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (r2 - CW'(den_q[k-1])) : r2;
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][OW-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[OW];
  assign ovf_o = ovf_q[OW];
endmodule

[hdl/plane_from_three_points.sv]
// Plane through three points by Cramer's rule: a*x + b*y + c*z + 1 = 0, with
// coefficients in Q31.16 truncated toward zero, clamped on overflow (status 2)
// and zero when the point determinant is zero (status 1). Fully pipelined: a
// new point triple is taken every cycle while the output is not stalled; most
// of the pipeline depth lies in the divider, which resolves one quotient bit
// per stage. A result that is not taken holds the whole pipeline.
module plane_from_three_points #(
  parameter int COORD_WIDTH = pftp_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = pftp_pkg::FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pftp_pts_if.sink       pts_i,
  pftp_coef_if.source    coef_o
);
  localparam int W   = COORD_WIDTH;
  localparam int OW  = pftp_pkg::OUT_WIDTH;
  localparam int PW  = 2 * W;
  localparam int MW  = 2 * W + 1;
  localparam int TW  = 3 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int SW  = 2 * W + 3;
  localparam int LAT = OW + 9;
  localparam logic [OW-1:0] LIM_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] LIM_NEG = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

  logic                 adv;
  logic [LAT-1:0]       vld_q;
  logic signed [W-1:0]  crd [3][3];
  logic signed [W-1:0]  xd_q [3][3];
  logic signed [PW-1:0] pm_a [3][3];
  logic signed [PW-1:0] pm_b [3][3];
  logic signed [MW-1:0] minor_q [3][3];
  logic signed [TW-1:0] tp [3];
  logic signed [SW-1:0] s_q [3][3];
  logic signed [DW-1:0] d_q;
  logic [SW-1:0]        sm_q [3];
  logic [DW-1:0]        dm_q;
  side_t                side_q;
  side_t                sb_q [OW+1];
  logic [OW-1:0]        quo [3];
  logic                 ovf [3];
  logic [OW-1:0]        coef_d [3];
  logic                 sat_d;
  logic signed [OW-1:0] coef_q [3];
  logic [1:0]           status_q;

  assign adv         = !vld_q[LAT-1] || coef_o.ready;
  assign pts_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], pts_i.valid};
    end
  end

  always_comb begin
    crd[0][0] = pts_i.x0; crd[0][1] = pts_i.y0; crd[0][2] = pts_i.z0;
    crd[1][0] = pts_i.x1; crd[1][1] = pts_i.y1; crd[1][2] = pts_i.z1;
    crd[2][0] = pts_i.x2; crd[2][1] = pts_i.y2; crd[2][2] = pts_i.z2;
  end

  // Minor t,p: 2x2 minor without column t and without row p.
  for (genvar t = 0; t < 3; t++) begin : g_col
    for (genvar p = 0; p < 3; p++) begin : g_row
      localparam int CA = (t == 0) ? 1 : 0;
      localparam int CB = (t == 2) ? 1 : 2;
      localparam int RI = (p == 0) ? 1 : 0;
      localparam int RJ = (p == 2) ? 1 : 2;

      pftp_mul #(.AW(W), .BW(W)) u_mul_a (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (crd[RI][CA]),
        .b_i   (crd[RJ][CB]),
        .p_o   (pm_a[t][p])
      );

      pftp_mul #(.AW(W), .BW(W)) u_mul_b (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (crd[RJ][CA]),
        .b_i   (crd[RI][CB]),
        .p_o   (pm_b[t][p])
      );
    end
  end

  // Expand the point determinant down the x column.
  for (genvar r = 0; r < 3; r++) begin : g_dterm
    pftp_mul #(.AW(MW), .BW(W)) u_mul_d (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (minor_q[0][r]),
      .b_i   (xd_q[2][r]),
      .p_o   (tp[r])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        xd_q[0][r] <= crd[r][0];
        xd_q[1][r] <= xd_q[0][r];
        xd_q[2][r] <= xd_q[1][r];
      end
      for (int t = 0; t < 3; t++) begin
        for (int p = 0; p < 3; p++) begin
          minor_q[t][p] <= MW'(pm_a[t][p]) - MW'(pm_b[t][p]);
        end
        s_q[0][t] <= SW'(minor_q[t][0]) - SW'(minor_q[t][1]) + SW'(minor_q[t][2]);
        s_q[1][t] <= s_q[0][t];
        s_q[2][t] <= s_q[1][t];
      end
      d_q <= DW'(tp[0]) - DW'(tp[1]) + DW'(tp[2]);

      for (int t = 0; t < 3; t++) begin
        sm_q[t] <= s_q[2][t][SW-1] ? SW'(-s_q[2][t]) : SW'(s_q[2][t]);
      end
      dm_q <= d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
      // Numerators of a and c carry the opposite sign of their sums.
      side_q.neg[0] <= ((s_q[2][0] != '0) && !s_q[2][0][SW-1]) ^ d_q[DW-1];
      side_q.neg[1] <= s_q[2][1][SW-1] ^ d_q[DW-1];
      side_q.neg[2] <= ((s_q[2][2] != '0) && !s_q[2][2][SW-1]) ^ d_q[DW-1];
      side_q.degen  <= d_q == '0;

      sb_q[0] <= side_q;
      for (int k = 1; k <= OW; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  for (genvar t = 0; t < 3; t++) begin : g_div
    pftp_div #(.NW(SW), .DW(DW), .SH(2 * FRAC_BITS), .OW(OW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (sm_q[t]),
      .den_i (dm_q),
      .quo_o (quo[t]),
      .ovf_o (ovf[t])
    );
  end

  always_comb begin
    logic sat;
    sat_d = 1'b0;
    for (int t = 0; t < 3; t++) begin
      sat = ovf[t] || (sb_q[OW].neg[t] ? (quo[t] > LIM_NEG) : (quo[t] > LIM_POS));
      sat_d = sat_d || sat;
      if (sb_q[OW].neg[t]) begin
        coef_d[t] = sat ? LIM_NEG : OW'(-quo[t]);
      end else begin
        coef_d[t] = sat ? LIM_POS : quo[t];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        coef_q[t] <= sb_q[OW].degen ? '0 : $signed(coef_d[t]);
      end
      if (sb_q[OW].degen) begin
        status_q <= pftp_pkg::STATUS_DEGEN;
      end else if (sat_d) begin
        status_q <= pftp_pkg::STATUS_SAT;
      end else begin
        status_q <= pftp_pkg::STATUS_OK;
      end
    end
  end

  assign coef_o.valid  = vld_q[LAT-1];
  assign coef_o.coef_a = coef_q[0];
  assign coef_o.coef_b = coef_q[1];
  assign coef_o.coef_c = coef_q[2];
  assign coef_o.status = status_q;
endmodule

[tb/plane_from_three_points_tb.sv]
`timescale 1ns / 1ps

module plane_from_three_points_tb;

  localparam int   HALF_PERIOD = 2;
  localparam int   RAND_ITEMS  = 1750;
  localparam int   PIPE_DEPTH  = 57;
  localparam logic signed [31:0] Q     = 32'sd65536;
  localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;

  typedef logic signed [159:0] wide_t;
  typedef logic signed [pftp_pkg::OUT_WIDTH-1:0] coef_t;

  typedef struct packed {
    logic signed [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
  } triple_t;

  typedef struct packed {
    coef_t             a, b, c;
    pftp_pkg::status_e st;
  } plane_t;

  typedef struct {
    triple_t p;
    bit      typed;
    plane_t  want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pftp_pts_if  pts ();
  pftp_coef_if coef ();

  plane_from_three_points DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pts_i  (pts),
    .coef_o (coef)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  plane_t        planes_due[$];
  directed_row_t directed[$];
  int            n_errors = 0;
  int            send_idle_pct = 28;
  int            recv_idle_pct = 77;

  function automatic wide_t det3(wide_t m00, wide_t m01, wide_t m02,
                                 wide_t m10, wide_t m11, wide_t m12,
                                 wide_t m20, wide_t m21, wide_t m22);
    return m00 * (m11 * m22 - m12 * m21) - m01 * (m10 * m22 - m12 * m20)
         + m02 * (m10 * m21 - m11 * m20);
  endfunction

  function automatic coef_t clamp_coef(wide_t q, inout bit sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (pftp_pkg::OUT_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (pftp_pkg::OUT_WIDTH - 1));
    if (q > hi) begin
      sat = 1'b1;
      return coef_t'(hi);
    end
    if (q < lo) begin
      sat = 1'b1;
      return coef_t'(lo);
    end
    return coef_t'(q);
  endfunction

  function automatic plane_t solve_plane(triple_t p);
    wide_t  x0, y0, z0, x1, y1, z1, x2, y2, z2, u, d, ea, eb, ec;
    bit     sat;
    plane_t r;
    x0 = p.x0; y0 = p.y0; z0 = p.z0;
    x1 = p.x1; y1 = p.y1; z1 = p.z1;
    x2 = p.x2; y2 = p.y2; z2 = p.z2;
    u = wide_t'(1) <<< pftp_pkg::FRAC_BITS;
    sat = 1'b0;
    d = det3(x0, y0, z0, x1, y1, z1, x2, y2, z2);
    if (d == 0) begin
      r.a = '0; r.b = '0; r.c = '0; r.st = pftp_pkg::STATUS_DEGEN;
      return r;
    end
    ea = det3(u, y0, z0, u, y1, z1, u, y2, z2);
    eb = det3(x0, u, z0, x1, u, z1, x2, u, z2);
    ec = det3(x0, y0, u, x1, y1, u, x2, y2, u);
    // signed division truncates toward zero
    r.a = clamp_coef(-(ea * u) / d, sat);
    r.b = clamp_coef(-(eb * u) / d, sat);
    r.c = clamp_coef(-(ec * u) / d, sat);
    r.st = sat ? pftp_pkg::STATUS_SAT : pftp_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic plane_t typed_plane(coef_t a, coef_t b, coef_t c,
                                         pftp_pkg::status_e st);
    plane_t r;
    r.a = a; r.b = b; r.c = c; r.st = st;
    return r;
  endfunction

  function automatic triple_t mk(logic signed [31:0] x0, y0, z0, x1, y1, z1,
                                 x2, y2, z2);
    return '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
  endfunction

  function automatic void add_row(triple_t p, bit typed, plane_t want);
    directed_row_t row;
    row.p = p;
    row.typed = typed;
    row.want = want;
    directed.insert(directed.size(), row);
  endfunction

  function automatic logic signed [31:0] small_coord(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic triple_t random_triple();
    triple_t p;
    int      mode;
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else if (mode <= 6) begin
      p = mk(small_coord(1 << 19), small_coord(1 << 19), small_coord(1 << 19),
             small_coord(1 << 19), small_coord(1 << 19), small_coord(1 << 19),
             small_coord(1 << 19), small_coord(1 << 19), small_coord(1 << 19));
    end else if (mode == 7) begin
      // collinear: third point repeats the first or the second
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           96'b0};
      if ($urandom_range(0, 1)) begin
        p.x2 = p.x0; p.y2 = p.y0; p.z2 = p.z0;
      end else begin
        p.x2 = p.x1; p.y2 = p.y1; p.z2 = p.z1;
      end
    end else if (mode == 8) begin
      // origin point puts the plane through the origin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      p.x1 = 0; p.y1 = 0; p.z1 = 0;
    end else begin
      // tiny coordinates keep the determinant small
      p = mk(small_coord(4), small_coord(4), small_coord(4),
             small_coord(4), small_coord(4), small_coord(4),
             small_coord(4), small_coord(4), small_coord(4));
    end
    return p;
  endfunction

  task automatic send_triple(triple_t p, bit typed, plane_t want);
    pts.valid <= 1'b1;
    {pts.x0, pts.y0, pts.z0, pts.x1, pts.y1, pts.z1, pts.x2, pts.y2, pts.z2} <= p;
    do @(posedge clk_i); while (!pts.ready);
    planes_due.insert(planes_due.size(), typed ? want : solve_plane(p));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pts.valid <= 1'b0;
      {pts.x0, pts.y0, pts.z0, pts.x1, pts.y1, pts.z1, pts.x2, pts.y2, pts.z2}
        <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom};
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef.ready <= 1'b0;
    end else begin
      coef.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (coef.valid && coef.ready) begin
        if (planes_due.size() == 0) begin
          $error("unexpected transfer: coef_a=%0d", coef.coef_a);
          n_errors++;
        end else begin
          plane_t w;
          w = planes_due.pop_front();
          if (coef.coef_a !== w.a) begin
            $error("coef_a: expected %0d, actual %0d", w.a, coef.coef_a);
            n_errors++;
          end
          if (coef.coef_b !== w.b) begin
            $error("coef_b: expected %0d, actual %0d", w.b, coef.coef_b);
            n_errors++;
          end
          if (coef.coef_c !== w.c) begin
            $error("coef_c: expected %0d, actual %0d", w.c, coef.coef_c);
            n_errors++;
          end
          if (coef.status !== w.st) begin
            $error("status: expected %0d, actual %0d", w.st, coef.status);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    plane_t none;
    none = typed_plane('0, '0, '0, pftp_pkg::STATUS_OK);
    pts.valid = 1'b0;
    {pts.x0, pts.y0, pts.z0, pts.x1, pts.y1, pts.z1, pts.x2, pts.y2, pts.z2} = '0;

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            typed_plane('0, '0, '0, pftp_pkg::STATUS_DEGEN));
    add_row(mk(Q, 0, 0, 0, Q, 0, 0, 0, Q), 1,
            typed_plane(-65536, -65536, -65536, pftp_pkg::STATUS_OK));
    add_row(mk(2 * Q, 0, 0, 0, 2 * Q, 0, 0, 0, 2 * Q), 1,
            typed_plane(-32768, -32768, -32768, pftp_pkg::STATUS_OK));
    add_row(mk(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
            typed_plane(-48'sd4294967296, -48'sd4294967296,
                        -48'sd4294967296, pftp_pkg::STATUS_OK));
    add_row(mk(Q, Q, Q, 2 * Q, 2 * Q, 2 * Q, 3 * Q, 3 * Q, 3 * Q), 1,
            typed_plane('0, '0, '0, pftp_pkg::STATUS_DEGEN));
    add_row(mk(0, 0, 0, Q, 0, 0, 0, Q, 0), 1,
            typed_plane('0, '0, '0, pftp_pkg::STATUS_DEGEN));
    add_row(mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
               C_MAX, C_MAX, C_MAX), 1,
            typed_plane('0, '0, '0, pftp_pkg::STATUS_DEGEN));
    add_row(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
               C_MIN, C_MIN, C_MIN), 1,
            typed_plane('0, '0, '0, pftp_pkg::STATUS_DEGEN));
    add_row(mk(1, 0, C_MAX, 0, 1, C_MAX, 0, 0, 1), 0, none);
    add_row(mk(1, 0, C_MIN, 0, 1, C_MIN, 0, 0, 1), 0, none);
    add_row(mk(C_MAX, C_MIN, 0, C_MIN, 0, C_MAX, 0, C_MAX, C_MIN), 0, none);
    add_row(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
               C_MIN, C_MAX, C_MIN), 0, none);
    add_row(mk(-1, 0, 0, 0, -1, 0, 0, 0, -1), 0, none);
    add_row(mk(C_MAX, 0, 0, 0, C_MAX, 0, 0, 0, C_MAX), 0, none);
    add_row(mk(C_MIN, 0, 0, 0, C_MIN, 0, 0, 0, C_MIN), 0, none);
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, 0), 0, none);
    add_row(mk(3 * Q, -Q, 5, 7, 2 * Q, -Q, -Q, 4, Q), 0, none);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_triple(directed[i].p, directed[i].typed, directed[i].want);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 28;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_triple(random_triple(), 0, none);
    end
    pts.valid <= 1'b0;

    while (planes_due.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[plane_from_three_points.f]
hdl/pftp_pkg.sv
hdl/pftp_pts_if.sv
hdl/pftp_coef_if.sv
hdl/pftp_mul.sv
hdl/pftp_div.sv
hdl/plane_from_three_points.sv
tb/plane_from_three_points_tb.sv
